// File: hdl/dsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants of the declaration syntax checker
// Holds the character beat and verdict types, the phase and status codes, and
// the keyword and type name tables with their match functions.
// ----------------------------------------------------------------------------
package dsc_pkg;

	localparam int FQ_DEPTH = 4;
	localparam int RQ_DEPTH = 2;
	localparam int POS_W    = 12;
	localparam int KW_COUNT = 12;
	localparam int TY_COUNT = 5;

	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] LEAD_0   = 8'h76;
	localparam logic [7:0] LEAD_1   = 8'h61;
	localparam logic [7:0] LEAD_2   = 8'h72;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_VAR    = 3'd1;
	localparam logic [2:0] ST_BAD_CHAR  = 3'd2;
	localparam logic [2:0] ST_BAD_FIRST = 3'd3;
	localparam logic [2:0] ST_KEYWORD   = 3'd4;
	localparam logic [2:0] ST_BAD_TYPE  = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_VAR      = 3'd1,
		PH_SKIP     = 3'd2,
		PH_ID_FIRST = 3'd3,
		PH_ID_REST  = 3'd4,
		PH_TYPE     = 3'd5,
		PH_AFTER    = 3'd6
	} phase_t;

	typedef logic [6:0][7:0] word7_t;

	// classified character beat handed from front to back
	typedef struct packed {
		logic [7:0]       ch;
		logic             start;
		logic             letter;
		logic             alnum;
		logic             comma;
		logic             colon;
		logic             semi;
		logic             var_hit;
		logic             var_last;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] pos_prev;
	} front_beat_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [POS_W-1:0] position;
	} result_t;

	// names stored as string literals: char i sits at byte (len-1-i)
	localparam word7_t     KW_WORD [KW_COUNT] = '{
		56'("var"), 56'("char"), 56'("integer"), 56'("string"), 56'("double"),
		56'("float"), 56'("if"), 56'("else"), 56'("switch"), 56'("for"),
		56'("do"), 56'("while")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd4, 4'd7, 4'd6, 4'd6, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd2, 4'd5
	};
	localparam word7_t     TY_WORD [TY_COUNT] = '{
		56'("integer"), 56'("double"), 56'("float"), 56'("char"), 56'("string")
	};
	localparam logic [3:0] TY_LEN [TY_COUNT] = '{
		4'd7, 4'd6, 4'd5, 4'd4, 4'd6
	};

	function automatic logic word_eq(input word7_t w, input logic [3:0] len,
		input word7_t ref_w, input logic [3:0] ref_len);
		logic hit;
		int   j;
		hit = (len == ref_len);
		for (int i = 0; i < 7; i++) begin
			j = int'(ref_len) - 1 - i;
			if (i < int'(ref_len) && w[i] != ref_w[j[2:0]])
				hit = 1'b0;
		end
		return hit;
	endfunction

	function automatic logic is_keyword(input word7_t w, input logic [3:0] len);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < KW_COUNT; k++)
			if (word_eq(w, len, KW_WORD[k], KW_LEN[k]))
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic is_type(input word7_t w, input logic [3:0] len);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < TY_COUNT; k++)
			if (word_eq(w, len, TY_WORD[k], TY_LEN[k]))
				hit = 1'b1;
		return hit;
	endfunction

endpackage

// File: hdl/dsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_front: character intake and classification
// Tracks the character index, classifies each character, and queues the
// classified beats for the back end.
// ----------------------------------------------------------------------------
module dsc_front #(
	parameter int MAX_TEXT = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           ch,
	input  logic                 start_req,
	output logic                 beat_valid,
	output dsc_pkg::front_beat_t beat,
	input  logic                 beat_take
);
	import dsc_pkg::*;

	localparam int CW  = $clog2(MAX_TEXT + 1);
	localparam int TOP = (MAX_TEXT - 1 > 4095) ? 4095 : MAX_TEXT - 1;
	localparam int PW  = $clog2(FQ_DEPTH);
	localparam int NW  = $clog2(FQ_DEPTH + 1);

	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_cur;
	logic [CW-1:0] idx_prev;
	front_beat_t   beat_in;
	front_beat_t   fq_q [FQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;
	logic          acc;

	assign full       = (cnt_q == NW'(FQ_DEPTH));
	assign acc        = push && !full;
	assign beat_valid = (cnt_q != '0);
	assign beat       = fq_q[rd_ptr_q];

	always_comb begin
		idx_cur  = start_req ? '0 : idx_q;
		idx_prev = idx_cur - CW'(1);
		beat_in.ch       = ch;
		beat_in.start    = start_req;
		beat_in.letter   = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
		beat_in.alnum    = beat_in.letter || (ch >= 8'h30 && ch <= 8'h39);
		beat_in.comma    = (ch == CH_COMMA);
		beat_in.colon    = (ch == CH_COLON);
		beat_in.semi     = (ch == CH_SEMI);
		beat_in.var_hit  = (idx_cur == CW'(0) && ch == LEAD_0) ||
			(idx_cur == CW'(1) && ch == LEAD_1) || (idx_cur == CW'(2) && ch == LEAD_2);
		beat_in.var_last = (idx_cur == CW'(2));
		beat_in.pos      = (idx_cur > CW'(TOP)) ? POS_W'(TOP) : POS_W'(idx_cur);
		beat_in.pos_prev = (idx_prev > CW'(TOP)) ? POS_W'(TOP) : POS_W'(idx_prev);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (acc) begin
				idx_q    <= (idx_cur < CW'(MAX_TEXT)) ? idx_cur + CW'(1) : idx_cur;
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (beat_take)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			cnt_q <= cnt_q + NW'(acc) - NW'(beat_take);
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			fq_q[wr_ptr_q] <= beat_in;
	end

	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		beat_take |-> cnt_q != '0) else $error("front queue read while empty");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(FQ_DEPTH)) else $error("front queue overfilled");
	a_start_idx: assert property (@(posedge clk) disable iff (!arst_n)
		acc && start_req |=> idx_q == CW'(1)) else $error("index not restarted");

endmodule

// File: hdl/dsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_back: grammar sequencer
// Steps the declaration grammar one classified beat per cycle while the
// verdict queue has room, collects the current word and issues the verdict.
// ----------------------------------------------------------------------------
module dsc_back #(
	parameter int WORD_CHARS = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 beat_valid,
	input  dsc_pkg::front_beat_t beat,
	output logic                 beat_take,
	input  logic                 res_full,
	output logic                 res_push,
	output dsc_pkg::result_t     res
);
	import dsc_pkg::*;

	localparam int LW = $clog2(WORD_CHARS + 2);

	phase_t                          phase_q, phase_d, ph;
	logic [WORD_CHARS-1:0][7:0]      buf_q, buf_d, wb, buf_add;
	logic [LW-1:0]                   len_q, len_d, wl, len_add;
	logic                            kw_hit, ty_hit;

	assign beat_take = beat_valid && !res_full;

	always_comb begin
		ph = beat.start ? PH_VAR : phase_q;
		wb = beat.start ? '0 : buf_q;
		wl = beat.start ? '0 : len_q;
		for (int i = 0; i < WORD_CHARS; i++)
			buf_add[i] = (wl < LW'(WORD_CHARS) && wl == LW'(i)) ? beat.ch : wb[i];
		len_add = (wl <= LW'(WORD_CHARS)) ? wl + LW'(1) : wl;
		kw_hit  = is_keyword(wb[6:0], 4'(wl));
		ty_hit  = is_type(wb[6:0], 4'(wl));

		phase_d      = phase_q;
		buf_d        = buf_q;
		len_d        = len_q;
		res_push     = 1'b0;
		res.status   = ST_OK;
		res.position = beat.pos;
		if (beat_take) begin
			phase_d = ph;
			buf_d   = wb;
			len_d   = wl;
			unique case (ph)
				PH_VAR: begin
					if (!beat.var_hit) begin
						res_push     = 1'b1;
						res.status   = ST_NO_VAR;
						res.position = '0;
						phase_d      = PH_IDLE;
					end else if (beat.var_last) begin
						phase_d = PH_SKIP;
					end
				end
				PH_SKIP: phase_d = PH_ID_FIRST;
				PH_ID_FIRST: begin
					if (!beat.letter) begin
						res_push   = 1'b1;
						res.status = ST_BAD_FIRST;
						phase_d    = PH_IDLE;
					end else begin
						buf_d    = '0;
						buf_d[0] = beat.ch;
						len_d    = LW'(1);
						phase_d  = PH_ID_REST;
					end
				end
				PH_ID_REST: begin
					if (beat.comma || beat.colon) begin
						if (kw_hit) begin
							res_push   = 1'b1;
							res.status = ST_KEYWORD;
							phase_d    = PH_IDLE;
						end else begin
							buf_d   = '0;
							len_d   = '0;
							phase_d = beat.colon ? PH_TYPE : PH_ID_FIRST;
						end
					end else if (beat.alnum) begin
						buf_d = buf_add;
						len_d = len_add;
					end else begin
						res_push   = 1'b1;
						res.status = ST_BAD_CHAR;
						phase_d    = PH_IDLE;
					end
				end
				PH_TYPE: begin
					if (beat.semi) begin
						buf_d = '0;
						len_d = '0;
						if (ty_hit) begin
							phase_d = PH_AFTER;
						end else begin
							res_push   = 1'b1;
							res.status = ST_BAD_TYPE;
							phase_d    = PH_IDLE;
						end
					end else begin
						buf_d = buf_add;
						len_d = len_add;
					end
				end
				PH_AFTER: begin
					if (beat.semi) begin
						res_push     = 1'b1;
						res.status   = ST_OK;
						res.position = beat.pos_prev;
						phase_d      = PH_IDLE;
					end else begin
						phase_d = PH_ID_FIRST;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			buf_q   <= '0;
			len_q   <= '0;
		end else begin
			phase_q <= phase_d;
			buf_q   <= buf_d;
			len_q   <= len_d;
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("verdict pushed into full queue");
	a_verdict_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> phase_q == PH_IDLE) else $error("phase not idle after verdict");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		beat_take && !beat.start && phase_q == PH_IDLE |-> !res_push)
		else $error("verdict while idle");

endmodule

// File: hdl/dsc_rq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_rq: verdict queue
// Holds finished verdicts until they are popped at the result port.
// ----------------------------------------------------------------------------
module dsc_rq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     res_push,
	output logic                     res_full,
	input  dsc_pkg::result_t         res,
	output logic                     empty,
	input  logic                     pop,
	output logic [2:0]               status,
	output logic [dsc_pkg::POS_W-1:0] position
);
	import dsc_pkg::*;

	localparam int PW = $clog2(RQ_DEPTH);
	localparam int NW = $clog2(RQ_DEPTH + 1);

	result_t       rq_q [RQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;
	logic          rd;

	assign empty    = (cnt_q == '0);
	assign res_full = (cnt_q == NW'(RQ_DEPTH));
	assign rd       = pop && !empty;
	assign status   = rq_q[rd_ptr_q].status;
	assign position = rq_q[rd_ptr_q].position;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (rd)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			cnt_q <= cnt_q + NW'(res_push) - NW'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			rq_q[wr_ptr_q] <= res;
	end

endmodule

// File: hdl/declaration_syntax_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// declaration_syntax_checker_unit: streaming declaration text checker
// Reads a declaration one character per beat and reports one verdict code
// with the character position at which the text was decided.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        ch, start_req
//  result    empty / pop        status, position
//
//  one character and one grammar beat per cycle while the verdict queue has room
//  a verdict is registered in the verdict queue and read from it at the result ports
//  the four-entry character queue absorbs back-end stalls from a full verdict queue
//  reset clears index, phase, word and both queues; the block waits for start_req
// ----------------------------------------------------------------------------
module declaration_syntax_checker_unit #(
	parameter int MAX_TEXT   = 4096,
	parameter int WORD_CHARS = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                ch,
	input  logic                      start_req,
	output logic                      empty,
	input  logic                      pop,
	output logic [2:0]                status,
	output logic [dsc_pkg::POS_W-1:0] position
);
	import dsc_pkg::*;

	logic        beat_valid;
	front_beat_t beat;
	logic        beat_take;
	logic        res_full;
	logic        res_push;
	result_t     res;

	dsc_front #(.MAX_TEXT(MAX_TEXT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.ch         (ch),
		.start_req  (start_req),
		.beat_valid (beat_valid),
		.beat       (beat),
		.beat_take  (beat_take)
	);

	dsc_back #(.WORD_CHARS(WORD_CHARS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (beat_valid),
		.beat       (beat),
		.beat_take  (beat_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	dsc_rq u_rq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_full (res_full),
		.res      (res),
		.empty    (empty),
		.pop      (pop),
		.status   (status),
		.position (position)
	);

endmodule
